### rtl/rpcf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the byte-wide CRC-16/XMODEM update for the request framer.
// No dependencies.
package rpcf_pkg;

   localparam logic [7:0]  ACK_BYTE      = 8'h06;
   localparam logic [7:0]  ETX_BYTE      = 8'h03;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [8:0]  TRAILER_BYTES = 9'd4;
   localparam logic [7:0]  LEN_MAX       = 8'hff;

   // Fold one byte into the CRC, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/request_packet_crc16_framer_unit.sv
`timescale 1ns / 1ps
// Request packet framer: ACK, payload, ETX, CRC-16/XMODEM low and high byte.
// Depends on rpcf_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_payload_byte, req_payload_end
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_frame_byte, rsp_frame_end, rsp_frame_length
//
// A request is taken into a one-entry stage; the CRC and count update happen on accept.
// The stage emits one frame byte per cycle into the output register while not stalled:
// the ACK if a request opens a frame, its byte, and ETX plus the CRC trailer if it closes one.
// A stalled output holds; the stage refills in the cycle its last byte moves out.
// Reset is synchronous and clears the stage, the output valid and the frame state.
module request_packet_crc16_framer_unit #(
   parameter int MAX_PAYLOAD = 251
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_payload_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_end,
   output logic [7:0] rsp_frame_length
);

   typedef enum logic [2:0] {
      PH_ACK,
      PH_DATA,
      PH_ETX,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   localparam logic [7:0] COUNT_MAX = 8'(MAX_PAYLOAD);

   // frame state
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic        in_frame_ff, in_frame_in;

   // one-request stage
   logic        stg_valid_ff, stg_valid_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  stg_byte_ff, stg_byte_in;
   logic        stg_last_ff, stg_last_in;
   logic [15:0] stg_crc_ff, stg_crc_in;
   logic [7:0]  stg_len_ff, stg_len_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;
   logic [7:0]  out_len_ff, out_len_in;

   logic        req_accept;
   logic        out_load;
   logic        last_emit;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [7:0]  count_base;
   logic [7:0]  count_next;
   logic [8:0]  len_wide;

   assign out_load  = stg_valid_ff && (!out_valid_ff || !rsp_stall);
   assign last_emit = (phase_ff == PH_CRC_HI) || (phase_ff == PH_DATA && !stg_last_ff);
   assign req_stall = stg_valid_ff && !(out_load && last_emit);
   assign req_accept = req_valid && !req_stall;

   assign crc_base   = in_frame_ff ? crc_ff : 16'h0000;
   assign count_base = in_frame_ff ? count_ff : 8'h00;
   assign crc_next   = rpcf_pkg::crc_feed(crc_base, req_payload_byte);
   assign count_next = (count_base < COUNT_MAX) ? count_base + 8'd1 : count_base;
   assign len_wide   = {1'b0, count_next} + rpcf_pkg::TRAILER_BYTES;

   always_comb begin
      crc_in      = crc_ff;
      count_in    = count_ff;
      in_frame_in = in_frame_ff;
      stg_valid_in = stg_valid_ff;
      phase_in    = phase_ff;
      stg_byte_in = stg_byte_ff;
      stg_last_in = stg_last_ff;
      stg_crc_in  = stg_crc_ff;
      stg_len_in  = stg_len_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in = out_byte_ff;
      out_end_in  = out_end_ff;
      out_len_in  = out_len_ff;

      if (out_load) begin
         out_valid_in = 1'b1;
         out_end_in   = 1'b0;
         out_len_in   = 8'h00;
         case (phase_ff)
            PH_ACK:    out_byte_in = rpcf_pkg::ACK_BYTE;
            PH_DATA:   out_byte_in = stg_byte_ff;
            PH_ETX:    out_byte_in = rpcf_pkg::ETX_BYTE;
            PH_CRC_LO: out_byte_in = stg_crc_ff[7:0];
            PH_CRC_HI: begin
               out_byte_in = stg_crc_ff[15:8];
               out_end_in  = 1'b1;
               out_len_in  = stg_len_ff;
            end
            default:   out_byte_in = 8'h00;
         endcase
         // advance the phase, or drop the stage after its last byte
         if (last_emit) begin
            stg_valid_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_ACK:    phase_in = PH_DATA;
               PH_DATA:   phase_in = PH_ETX;
               PH_ETX:    phase_in = PH_CRC_LO;
               PH_CRC_LO: phase_in = PH_CRC_HI;
               default:   phase_in = PH_CRC_HI;
            endcase
         end
      end

      if (req_accept) begin
         stg_valid_in = 1'b1;
         phase_in     = in_frame_ff ? PH_DATA : PH_ACK;
         stg_byte_in  = req_payload_byte;
         stg_last_in  = req_payload_end;
         stg_crc_in   = crc_next;
         stg_len_in   = len_wide[8] ? rpcf_pkg::LEN_MAX : len_wide[7:0];
         if (req_payload_end) begin
            crc_in      = 16'h0000;
            count_in    = 8'h00;
            in_frame_in = 1'b0;
         end else begin
            crc_in      = crc_next;
            count_in    = count_next;
            in_frame_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= 16'h0000;
         count_ff     <= 8'h00;
         in_frame_ff  <= 1'b0;
         stg_valid_ff <= 1'b0;
         phase_ff     <= PH_ACK;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         in_frame_ff  <= in_frame_in;
         stg_valid_ff <= stg_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      stg_byte_ff <= stg_byte_in;
      stg_last_ff <= stg_last_in;
      stg_crc_ff  <= stg_crc_in;
      stg_len_ff  <= stg_len_in;
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_byte   = out_byte_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_frame_length = out_len_ff;

endmodule

### rtl/rpcf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the request framer, bound to the top level.
// Depends only on the top level's ports.
module rpcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_frame_end,
   input logic [7:0] rsp_frame_length
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_frame_end) && $stable(rsp_frame_length))
      else $error("stalled response changed");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_frame_length == 8'h00)
      else $error("frame length set on a non-closing byte");

   a_len_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_frame_length >= 8'd5)
      else $error("closing frame length below minimum");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the pipeline");

endmodule

bind request_packet_crc16_framer_unit rpcf_checker u_rpcf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_byte   (rsp_frame_byte),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_frame_length (rsp_frame_length)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for request_packet_crc16_framer_unit: framed bytes are predicted
// per request (ACK, payload, ETX, CRC-16/XMODEM trailer) and checked in order.
// Depends on rpcf_pkg and the framer RTL.
module tb_top;

   localparam int MAX_PAYLOAD = 251;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic [7:0] frame_length;
   } frame_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_payload_byte = 8'h00;
   logic       req_payload_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic       rsp_frame_end;
   logic [7:0] rsp_frame_length;

   // predictor state
   logic [15:0] crc_acc = 16'h0000;
   logic        in_packet = 1'b0;
   logic [7:0]  payload_count = 8'd0;

   frame_out_type expected_frame[$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int error_count = 0;
   int requests_sent = 0;
   int packets_sent = 0;
   int bytes_checked = 0;
   int frames_closed = 0;

   request_packet_crc16_framer_unit #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload_byte(req_payload_byte),
      .req_payload_end (req_payload_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_length(rsp_frame_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shift the byte in MSB first, feedback from the top bit against the data bit
   function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] acc,
                                                     input logic [7:0] octet);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ octet[i];
         acc = {acc[14:0], 1'b0};
         if (fb) begin
            acc = acc ^ rpcf_pkg::CRC_POLY;
         end
      end
      return acc;
   endfunction

   function automatic frame_out_type frame_out(input logic [7:0] b, input logic e,
                                               input logic [7:0] len);
      frame_out_type f;
      f.frame_byte   = b;
      f.frame_end    = e;
      f.frame_length = len;
      return f;
   endfunction

   task automatic predict_frame_bytes(input logic [7:0] octet, input logic is_last);
      logic [8:0] total;
      if (!in_packet) begin
         expected_frame.push_back(frame_out(rpcf_pkg::ACK_BYTE, 1'b0, 8'd0));
         in_packet     = 1'b1;
         crc_acc       = 16'h0000;
         payload_count = 8'd0;
      end
      expected_frame.push_back(frame_out(octet, 1'b0, 8'd0));
      crc_acc = crc16_xmodem_step(crc_acc, octet);
      if (payload_count < MAX_PAYLOAD) begin
         payload_count = payload_count + 8'd1;
      end
      if (is_last) begin
         total = {1'b0, payload_count} + 9'd4;
         if (total > 9'h0ff) begin
            total = 9'h0ff;
         end
         expected_frame.push_back(frame_out(rpcf_pkg::ETX_BYTE, 1'b0, 8'd0));
         expected_frame.push_back(frame_out(crc_acc[7:0], 1'b0, 8'd0));
         expected_frame.push_back(frame_out(crc_acc[15:8], 1'b1, total[7:0]));
         in_packet     = 1'b0;
         crc_acc       = 16'h0000;
         payload_count = 8'd0;
         packets_sent++;
      end
   endtask

   // Send one request; idle before it at the current rate, hold until accepted
   task automatic send_request(input logic [7:0] octet, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_payload_byte <= 8'($urandom_range(0, 255));
         req_payload_end  <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= octet;
      req_payload_end  <= is_last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_frame_bytes(octet, is_last);
      requests_sent++;
   endtask

   always @(posedge clock) begin : rsp_check
      frame_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frame.size() == 0) begin
               $error("unexpected frame byte %02h, nothing pending", rsp_frame_byte);
               error_count++;
            end else begin
               want = expected_frame.pop_front();
               bytes_checked++;
               if (rsp_frame_byte !== want.frame_byte) begin
                  $error("frame_byte: expected %02h, actual %02h",
                         want.frame_byte, rsp_frame_byte);
                  error_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, actual %0b",
                         want.frame_end, rsp_frame_end);
                  error_count++;
               end
               if (rsp_frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, actual %0d",
                         want.frame_length, rsp_frame_length);
                  error_count++;
               end
               if (want.frame_end) begin
                  frames_closed++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   task automatic test_single_byte_packets();
      send_request(8'h00, 1'b1);
      send_request(8'hff, 1'b1);
      send_request(8'h80, 1'b1);
      send_request(8'h7f, 1'b1);
   endtask

   // Payload bytes that look like framing bytes must pass through untouched
   task automatic test_short_packets();
      logic [7:0] mixed[6] = '{8'h06, 8'h03, 8'h55, 8'haa, 8'h01, 8'hfe};
      send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_request(mixed[i], i == 5);
      end
   endtask

   // "123456789" gives the well-known check value 0x31c3
   task automatic test_check_string();
      for (int i = 0; i < 9; i++) begin
         send_request(8'h31 + 8'(i), i == 8);
      end
   endtask

   // Run the count one byte past its ceiling
   task automatic test_overlong_payload();
      for (int i = 0; i <= MAX_PAYLOAD; i++) begin
         send_request(8'($urandom_range(0, 255)), i == MAX_PAYLOAD);
      end
   endtask

   task automatic test_random_packets(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         case (sent * 3 / budget)
            0: begin
               send_idle_pct = 16;
               rsp_idle_pct  = 58;
            end
            1: begin
               send_idle_pct = 58;
               rsp_idle_pct  = 16;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         if (len > budget - sent) begin
            len = budget - sent;
         end
         for (int i = 0; i < len; i++) begin
            send_request(8'($urandom_range(0, 255)), i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 16;
      rsp_idle_pct  = 58;
      test_single_byte_packets();
      test_short_packets();
      test_check_string();

      send_idle_pct = 58;
      rsp_idle_pct  = 16;
      test_overlong_payload();

      test_random_packets(16);
      req_valid <= 1'b0;

      while (expected_frame.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (expected_frame.size() != 0) begin
         $error("%0d frame bytes never arrived", expected_frame.size());
         error_count++;
      end

      $display("covered %0d requests in %0d packets, incl. single-byte and overlong frames",
               requests_sent, packets_sent);
      $display("checked %0d frame bytes, %0d closed frames, %0d mismatches",
               bytes_checked, frames_closed, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d frame bytes still pending", expected_frame.size());
      $display("status: fail");
      $finish;
   end

endmodule
